// ----- rtl/csrmm_pkg.sv -----
`timescale 1ns / 1ps
package csrmm_pkg;

  localparam int OP_W       = 2;
  localparam int POS_W      = 3;
  localparam int VAL_W      = 32;
  localparam int DIM_REG_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = 64;
  localparam int FRAC_W     = 16;

  localparam int DEFAULT_MAX_DIM      = 8;
  localparam int DEFAULT_MAX_NONZEROS = 64;

  // results emitted per compute word are capped here
  localparam int RESULT_LIMIT = 64;
  localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT_B = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_ROW,
    ST_A_END,
    ST_C_START,
    ST_C_END,
    ST_C_NZ,
    ST_C_BRD,
    ST_C_MUL,
    ST_C_ACC,
    ST_C_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

endpackage

// ----- rtl/csrmm_in_if.sv -----
`timescale 1ns / 1ps
interface csrmm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [csrmm_pkg::OP_W-1:0]           operation;
  logic [csrmm_pkg::POS_W-1:0]          row;
  logic [csrmm_pkg::POS_W-1:0]          col;
  logic signed [csrmm_pkg::VAL_W-1:0]   value;

  modport source (output valid, output operation, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input operation, input row, input col, input value,
                  output ready);
endinterface

// ----- rtl/csrmm_out_if.sv -----
`timescale 1ns / 1ps
interface csrmm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [csrmm_pkg::POS_W-1:0]          out_row;
  logic [csrmm_pkg::POS_W-1:0]          out_col;
  logic signed [csrmm_pkg::VAL_W-1:0]   product;
  logic                                 saturated;
  logic                                 last;

  modport source (output valid, output out_row, output out_col, output product,
                  output saturated, output last, input ready);
  modport sink   (input valid, input out_row, input out_col, input product,
                  input saturated, input last, output ready);
endinterface

// ----- rtl/csr_sparse_dense_matmul.sv -----
`timescale 1ns / 1ps
// channel  | dir | handshake     | word
// ---------+-----+---------------+-----------------------------------------------
// items    | in  | valid / ready | operation, row, col, value
// results  | out | valid / ready | out_row, out_col, product, saturated, last
// cfg      | in  | cfg_we        | cfg_index, cfg_data (no read-back)
//
// Load B writes on accept; load A does up to two row-start writes on one RAM port.
// Compute per result (max 64): row-start reads, read/mul/add per nonzero, emit;
// one shared multiply-accumulate unit fed by registered reads, one read port per RAM.
// Ready is low while a word is at work and while a result waits on a full output.
// Reset clears the nonzero count, row-start valid bits and sets dimensions to 8;
// the value, column and B stores hold garbage until written.
module csr_sparse_dense_matmul #(
  parameter int MAX_DIM      = csrmm_pkg::DEFAULT_MAX_DIM,
  parameter int MAX_NONZEROS = csrmm_pkg::DEFAULT_MAX_NONZEROS
) (
  input  logic                                clk,
  input  logic                                rst,
  csrmm_in_if.sink                            items,
  csrmm_out_if.source                         results,
  input  logic                                cfg_we,
  input  logic [csrmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csrmm_pkg::DIM_REG_W-1:0]     cfg_data
);

  localparam int POS_W    = csrmm_pkg::POS_W;
  localparam int VAL_W    = csrmm_pkg::VAL_W;
  localparam int RES_W    = csrmm_pkg::RES_CNT_W;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int RS_DEPTH = MAX_DIM + 1;
  localparam int CNT_W    = $clog2(MAX_NONZEROS + 1);
  localparam int NZ_AW    = $clog2(MAX_NONZEROS);
  localparam int NZ_W     = POS_W + VAL_W;
  localparam int B_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int B_AW     = $clog2(B_DEPTH);

  csrmm_pkg::state_t state, state_next;

  logic [csrmm_pkg::DIM_REG_W-1:0] row_count_a;
  logic [csrmm_pkg::DIM_REG_W-1:0] inner_size;
  logic [csrmm_pkg::DIM_REG_W-1:0] col_count_b;
  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] inner;
  logic [DIM_W-1:0] cols;

  logic             in_ready;
  logic             in_acc;
  logic             a_in_range;
  logic             b_in_range;

  logic [POS_W-1:0]        a_row;
  logic [POS_W-1:0]        a_col;
  logic signed [VAL_W-1:0] a_val;
  logic                    a_clear;
  logic [CNT_W-1:0]        cnt_eff;
  logic                    nz_keep;

  logic [CNT_W-1:0]    nz_count;
  logic [RS_DEPTH-1:0] rs_valid;

  logic             rs_we;
  logic [DIM_W-1:0] rs_waddr;
  logic [CNT_W-1:0] rs_wdata;
  logic             rs_re;
  logic [DIM_W-1:0] rs_raddr;
  logic [CNT_W-1:0] rs_rdata;
  logic             rs_vld_q;
  logic [CNT_W-1:0] rs_val;

  logic             nz_we;
  logic             nz_re;
  logic [NZ_W-1:0]  nz_rdata;
  logic [POS_W-1:0] nz_col;
  logic signed [VAL_W-1:0] nz_val;

  logic             b_we;
  logic             b_re;
  logic [B_AW-1:0]  b_waddr;
  logic [B_AW-1:0]  b_raddr;
  logic [VAL_W-1:0] b_rdata;

  logic [DIM_W-1:0] i_idx;
  logic [DIM_W-1:0] j_idx;
  logic [CNT_W-1:0] k_idx;
  logic [RES_W-1:0] n_cnt;
  logic             last_elem;

  csrmm_pkg::mac_ctl_t     mac_ctl;
  logic signed [VAL_W-1:0] mac_sum;
  logic                    mac_sat;

  logic                    out_valid;
  logic                    out_free;
  logic                    out_load;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_product;
  logic                    out_sat;
  logic                    out_last;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [csrmm_pkg::DIM_REG_W-1:0] d);
    logic [31:0] d32;
    d32 = 32'(d);
    return (d32 > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(d32);
  endfunction

  assign rows  = clamp_dim(row_count_a);
  assign inner = clamp_dim(inner_size);
  assign cols  = clamp_dim(col_count_b);

  assign items.ready = in_ready;
  assign in_acc      = items.valid && in_ready;

  assign a_in_range = (32'(items.row) < 32'(rows)) && (32'(items.col) < 32'(inner));
  assign b_in_range = (32'(items.row) < 32'(inner)) && (32'(items.col) < 32'(cols));

  // row 0 column 0 restarts the compressed store
  assign a_clear = (a_row == '0) && (a_col == '0);
  assign cnt_eff = a_clear ? '0 : nz_count;
  assign nz_keep = (a_val != '0) && (cnt_eff < CNT_W'(MAX_NONZEROS));

  // row starts never written read as zero
  assign rs_val = rs_vld_q ? rs_rdata : '0;

  assign nz_col = nz_rdata[NZ_W-1 -: POS_W];
  assign nz_val = nz_rdata[VAL_W-1:0];

  assign b_waddr = B_AW'(32'(items.row) * MAX_DIM + 32'(items.col));
  assign b_raddr = B_AW'(32'(nz_col) * MAX_DIM + 32'(j_idx));

  assign last_elem = (n_cnt == RES_W'(csrmm_pkg::RESULT_LIMIT - 1)) ||
                     ((i_idx == rows - DIM_W'(1)) && (j_idx == cols - DIM_W'(1)));

  assign out_free = !out_valid || results.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      csrmm_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (items.operation)
            csrmm_pkg::OP_LOAD_A: begin
              if (a_in_range) state_next = csrmm_pkg::ST_A_ROW;
            end
            csrmm_pkg::OP_COMPUTE: begin
              if (rows != '0 && cols != '0) state_next = csrmm_pkg::ST_C_START;
            end
            default: state_next = csrmm_pkg::ST_IDLE;
          endcase
        end
      end
      csrmm_pkg::ST_A_ROW:   state_next = csrmm_pkg::ST_A_END;
      csrmm_pkg::ST_A_END:   state_next = csrmm_pkg::ST_IDLE;
      csrmm_pkg::ST_C_START: state_next = csrmm_pkg::ST_C_END;
      csrmm_pkg::ST_C_END:   state_next = csrmm_pkg::ST_C_NZ;
      csrmm_pkg::ST_C_NZ: begin
        state_next = (k_idx < rs_val) ? csrmm_pkg::ST_C_BRD : csrmm_pkg::ST_C_EMIT;
      end
      csrmm_pkg::ST_C_BRD:   state_next = csrmm_pkg::ST_C_MUL;
      csrmm_pkg::ST_C_MUL:   state_next = csrmm_pkg::ST_C_ACC;
      csrmm_pkg::ST_C_ACC:   state_next = csrmm_pkg::ST_C_NZ;
      csrmm_pkg::ST_C_EMIT: begin
        if (out_free) begin
          state_next = last_elem ? csrmm_pkg::ST_IDLE : csrmm_pkg::ST_C_START;
        end
      end
      default: state_next = csrmm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rs_we    = 1'b0;
    rs_waddr = DIM_W'(a_row);
    rs_wdata = cnt_eff;
    rs_re    = 1'b0;
    rs_raddr = i_idx;
    nz_we    = 1'b0;
    nz_re    = 1'b0;
    b_we     = 1'b0;
    b_re     = 1'b0;
    mac_ctl  = '0;
    out_load = 1'b0;
    unique case (state)
      csrmm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        b_we     = in_acc && (items.operation == csrmm_pkg::OP_LOAD_B) && b_in_range;
      end
      csrmm_pkg::ST_A_ROW: begin
        rs_we = (a_col == '0);
        nz_we = nz_keep;
      end
      csrmm_pkg::ST_A_END: begin
        rs_we    = 1'b1;
        rs_waddr = DIM_W'(32'(a_row) + 32'd1);
        rs_wdata = nz_count;
      end
      csrmm_pkg::ST_C_START: begin
        rs_re = 1'b1;
      end
      csrmm_pkg::ST_C_END: begin
        rs_re       = 1'b1;
        rs_raddr    = i_idx + DIM_W'(1);
        mac_ctl.clr = 1'b1;
      end
      csrmm_pkg::ST_C_NZ:   nz_re = (k_idx < rs_val);
      csrmm_pkg::ST_C_BRD:  b_re = 1'b1;
      csrmm_pkg::ST_C_MUL:  mac_ctl.mul_en = 1'b1;
      csrmm_pkg::ST_C_ACC:  mac_ctl.acc_en = 1'b1;
      csrmm_pkg::ST_C_EMIT: out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= csrmm_pkg::ST_IDLE;
      row_count_a <= csrmm_pkg::DIM_RESET;
      inner_size  <= csrmm_pkg::DIM_RESET;
      col_count_b <= csrmm_pkg::DIM_RESET;
      nz_count    <= '0;
      rs_valid    <= '0;
      i_idx       <= '0;
      j_idx       <= '0;
      k_idx       <= '0;
      n_cnt       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          csrmm_pkg::REG_ROW_COUNT_A: row_count_a <= cfg_data;
          csrmm_pkg::REG_INNER_SIZE:  inner_size  <= cfg_data;
          csrmm_pkg::REG_COL_COUNT_B: col_count_b <= cfg_data;
          default: ;
        endcase
      end

      if (state == csrmm_pkg::ST_A_ROW) begin
        nz_count <= cnt_eff + CNT_W'(nz_keep);
      end

      if ((state == csrmm_pkg::ST_A_ROW) && a_clear) begin
        rs_valid <= RS_DEPTH'(1);
      end else if (rs_we) begin
        rs_valid[rs_waddr] <= 1'b1;
      end

      if (in_acc) begin
        i_idx <= '0;
        j_idx <= '0;
        n_cnt <= '0;
      end
      if (state == csrmm_pkg::ST_C_END) begin
        k_idx <= rs_val;
      end
      if (state == csrmm_pkg::ST_C_ACC) begin
        k_idx <= k_idx + CNT_W'(1);
      end
      if (out_load) begin
        n_cnt <= n_cnt + RES_W'(1);
        if (i_idx == rows - DIM_W'(1)) begin
          i_idx <= '0;
          j_idx <= j_idx + DIM_W'(1);
        end else begin
          i_idx <= i_idx + DIM_W'(1);
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_row <= items.row;
      a_col <= items.col;
      a_val <= items.value;
    end
    if (rs_re) begin
      rs_vld_q <= rs_valid[rs_raddr];
    end
    if (out_load) begin
      out_row     <= POS_W'(i_idx);
      out_col     <= POS_W'(j_idx);
      out_product <= mac_sum;
      out_sat     <= mac_sat;
      out_last    <= last_elem;
    end
  end

  assign results.valid     = out_valid;
  assign results.out_row   = out_row;
  assign results.out_col   = out_col;
  assign results.product   = out_product;
  assign results.saturated = out_sat;
  assign results.last      = out_last;

  csrmm_ram #(
    .WIDTH (CNT_W),
    .DEPTH (RS_DEPTH)
  ) u_row_starts (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .re    (rs_re),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  csrmm_ram #(
    .WIDTH (NZ_W),
    .DEPTH (MAX_NONZEROS)
  ) u_nonzeros (
    .clk   (clk),
    .we    (nz_we),
    .waddr (NZ_AW'(cnt_eff)),
    .wdata ({a_col, a_val}),
    .re    (nz_re),
    .raddr (NZ_AW'(k_idx)),
    .rdata (nz_rdata)
  );

  csrmm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (B_DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (items.value),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  csrmm_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (nz_val),
    .b   (b_rdata),
    .sum (mac_sum),
    .sat (mac_sat)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    nz_count <= CNT_W'(MAX_NONZEROS))
    else $error("nonzero count beyond store depth");

  a_nz_read_bound: assert property (@(posedge clk) disable iff (rst)
    nz_re |-> (k_idx < CNT_W'(MAX_NONZEROS)))
    else $error("nonzero read past store");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (n_cnt < RES_W'(csrmm_pkg::RESULT_LIMIT)))
    else $error("too many results in one compute word");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_elem) |=> (state == csrmm_pkg::ST_IDLE))
    else $error("sequencer kept running after last result");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == csrmm_pkg::ST_C_ACC) |-> ($past(state) == csrmm_pkg::ST_C_MUL))
    else $error("accumulate without fresh product");
`endif

endmodule

// ----- rtl/csrmm_ram.sv -----
`timescale 1ns / 1ps
module csrmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/csrmm_mac.sv -----
`timescale 1ns / 1ps
module csrmm_mac (
  input  logic                                clk,
  input  csrmm_pkg::mac_ctl_t                 ctl,
  input  logic signed [csrmm_pkg::VAL_W-1:0]  a,
  input  logic signed [csrmm_pkg::VAL_W-1:0]  b,
  output logic signed [csrmm_pkg::VAL_W-1:0]  sum,
  output logic                                sat
);

  localparam int VW = csrmm_pkg::VAL_W;
  localparam int AW = csrmm_pkg::ACC_W;

  logic signed [AW-1:0] a_ext;
  logic signed [AW-1:0] b_ext;
  logic signed [AW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic                 hi_ones;
  logic                 hi_zeros;

  assign a_ext = {{(AW - VW){a[VW-1]}}, a};
  assign b_ext = {{(AW - VW){b[VW-1]}}, b};

  // product is registered before it reaches the adder
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a_ext * b_ext;
    end
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      // arithmetic shift floors toward minus infinity
      acc <= acc + (prod >>> csrmm_pkg::FRAC_W);
    end
  end

  // upper bits must all match the sign for the sum to fit in 32 bits
  assign hi_ones  = &acc[AW-1:VW-1];
  assign hi_zeros = ~|acc[AW-1:VW-1];
  assign sat      = !(hi_ones || hi_zeros);

  always_comb begin
    if (!sat) begin
      sum = acc[VW-1:0];
    end else if (acc[AW-1]) begin
      sum = {1'b1, {(VW - 1){1'b0}}};
    end else begin
      sum = {1'b0, {(VW - 1){1'b1}}};
    end
  end

endmodule
